>>> hw/rtl/tsc_pkg.sv
// tsc_pkg: shared widths, command/status structs and saturation helpers
// used by the trajectory smoothing corrector controller and datapath
// no dependencies
package tsc_pkg;

    localparam int HISTORY_DEPTH = 128;
    localparam int MAX_RADIUS    = 63;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int RADIUS_W      = 6;
    localparam int STEP_W        = 19;
    localparam int PATH_W        = 40;
    localparam int SUM_W         = 48;
    localparam int OUT_W         = 24;
    localparam int CNT_W         = 7;
    localparam int LANES         = 3;
    localparam int DIV_STEPS     = SUM_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam int REM_W         = CNT_W + 1;
    localparam int RAM_W         = LANES * PATH_W;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd15;

    typedef struct packed {
        logic              load;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              rd_sum;
        logic              rd_prev;
        logic              prev_clear;
        logic              acc_clear;
        logic              div_start;
        logic [CNT_W-1:0]  count;
        logic              out_load;
        logic              out_last;
        logic              seq_clear;
    } tsc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } tsc_status_t;

    function automatic logic signed [PATH_W-1:0] sat_path(input logic signed [PATH_W:0] v);
        logic signed [PATH_W:0] hi;
        logic signed [PATH_W:0] lo;
        hi = (PATH_W+1)'((65'sd1 <<< (PATH_W-1)) - 65'sd1);
        lo = -hi - (PATH_W+1)'(1);
        if (v > hi)
            return hi[PATH_W-1:0];
        else if (v < lo)
            return lo[PATH_W-1:0];
        else
            return v[PATH_W-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W:0] v);
        logic signed [SUM_W:0] hi;
        logic signed [SUM_W:0] lo;
        hi = (SUM_W+1)'((65'sd1 <<< (OUT_W-1)) - 65'sd1);
        lo = -hi - (SUM_W+1)'(1);
        if (v > hi)
            return hi[OUT_W-1:0];
        else if (v < lo)
            return lo[OUT_W-1:0];
        else
            return v[OUT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/tsc_ram.sv
// tsc_ram: generic single write port, single read port ram, registered read
// no dependencies
module tsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/tsc_datapath.sv
// tsc_datapath: running trajectory, history ram, window accumulators,
// serial dividers and the output register; depends on tsc_pkg and tsc_ram
module tsc_datapath
    import tsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  tsc_cmd_t                 cmd,
    output tsc_status_t              status,
    input  logic [LANES*STEP_W-1:0]  steps,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [LANES*OUT_W-1:0]   out_data,
    output logic                     out_last
);

    logic signed [PATH_W-1:0] running_reg  [LANES];
    logic signed [PATH_W-1:0] running_next [LANES];
    logic signed [SUM_W-1:0]  acc_reg      [LANES];
    logic signed [PATH_W-1:0] prev_reg     [LANES];
    logic [SUM_W-1:0]         dq_reg       [LANES];
    logic [REM_W-1:0]         drem_reg     [LANES];
    logic                     dneg_reg     [LANES];
    logic [CNT_W-1:0]         divisor_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic                     div_busy_reg;
    logic                     sum_pend_reg;
    logic                     prev_pend_reg;
    logic                     out_valid_reg;
    logic                     out_last_reg;
    logic [LANES*OUT_W-1:0]   out_data_reg;
    logic [LANES*OUT_W-1:0]   out_data_next;
    logic [RAM_W-1:0]         wr_data;
    logic [RAM_W-1:0]         rd_data;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            running_next[l] = sat_path(
                {running_reg[l][PATH_W-1], running_reg[l]}
                + (PATH_W+1)'(signed'(steps[l*STEP_W +: STEP_W])));
            wr_data[l*PATH_W +: PATH_W] = running_next[l];
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] qs;
        for (int l = 0; l < LANES; l++)
        begin
            qs = dneg_reg[l] ? -signed'(dq_reg[l]) : signed'(dq_reg[l]);
            out_data_next[l*OUT_W +: OUT_W] = sat_out(
                (SUM_W+1)'(qs) - (SUM_W+1)'(prev_reg[l]));
        end
    end

    tsc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (cmd.load),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    // running trajectory and read-data bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                running_reg[l] <= '0;
            end
            sum_pend_reg  <= 1'b0;
            prev_pend_reg <= 1'b0;
        end
        else
        begin
            sum_pend_reg  <= cmd.rd_sum;
            prev_pend_reg <= cmd.rd_prev;
            for (int l = 0; l < LANES; l++)
            begin
                if (cmd.seq_clear)
                    running_reg[l] <= '0;
                else if (cmd.load)
                    running_reg[l] <= running_next[l];
            end
        end
    end

    // accumulators, previous point and restoring dividers (one lane per channel)
    always_ff @(posedge clk)
    begin
        logic [REM_W-1:0] rsh;
        for (int l = 0; l < LANES; l++)
        begin
            if (cmd.acc_clear)
                acc_reg[l] <= '0;
            else if (sum_pend_reg)
                acc_reg[l] <= acc_reg[l] + SUM_W'(signed'(rd_data[l*PATH_W +: PATH_W]));
            if (cmd.prev_clear)
                prev_reg[l] <= '0;
            else if (prev_pend_reg)
                prev_reg[l] <= rd_data[l*PATH_W +: PATH_W];
            if (cmd.div_start)
            begin
                dneg_reg[l] <= acc_reg[l][SUM_W-1];
                dq_reg[l]   <= acc_reg[l][SUM_W-1] ? unsigned'(-acc_reg[l])
                                                   : unsigned'(acc_reg[l]);
                drem_reg[l] <= '0;
            end
            else if (div_busy_reg)
            begin
                rsh = {drem_reg[l][REM_W-2:0], dq_reg[l][SUM_W-1]};
                if (rsh >= {1'b0, divisor_reg})
                begin
                    drem_reg[l] <= rsh - {1'b0, divisor_reg};
                    dq_reg[l]   <= {dq_reg[l][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg[l] <= rsh;
                    dq_reg[l]   <= {dq_reg[l][SUM_W-2:0], 1'b0};
                end
            end
        end
        if (cmd.div_start)
            divisor_reg <= cmd.count;
        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    div_busy_reg <= 1'b0;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.div_done = div_busy_reg && (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign out_last        = out_last_reg;

endmodule

>>> hw/rtl/tsc_controller.sv
// tsc_controller: sequencer for window reads, division and result hand-off,
// plus history pointers and the radius register; depends on tsc_pkg
module tsc_controller
    import tsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [RADIUS_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_final,
    output tsc_cmd_t            cmd,
    input  tsc_status_t         status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_PREV,
        ST_LAND,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [RADIUS_W-1:0] radius_reg;
    logic [ADDR_W-1:0]   wp_reg;
    logic [CNT_W-1:0]    pending_reg;
    logic [CNT_W-1:0]    emitted_reg;
    logic [ADDR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]    remain_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                final_reg;
    logic                due;
    logic [CNT_W-1:0]    back;
    logic [CNT_W-1:0]    ahead;
    logic [ADDR_W-1:0]   base;
    logic                accept;

    assign accept = in_valid && in_ready;
    assign base   = wp_reg - ADDR_W'(pending_reg);
    assign due    = (pending_reg > CNT_W'(radius_reg)) || (final_reg && pending_reg != '0);
    assign back   = (emitted_reg < CNT_W'(radius_reg)) ? emitted_reg : CNT_W'(radius_reg);
    assign ahead  = ((pending_reg - CNT_W'(1)) < CNT_W'(radius_reg))
                    ? pending_reg - CNT_W'(1) : CNT_W'(radius_reg);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.wr_addr    = wp_reg;
        cmd.rd_addr    = rd_ptr_reg;
        cmd.count      = count_reg;
        cmd.out_last   = final_reg && (pending_reg == CNT_W'(1));
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (due)
                begin
                    cmd.acc_clear = 1'b1;
                    state_next    = ST_SUM;
                end
                else
                begin
                    cmd.seq_clear = final_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sum = 1'b1;
                if (remain_reg == CNT_W'(1))
                    state_next = ST_PREV;
            end
            ST_PREV:
            begin
                cmd.rd_addr = base - ADDR_W'(1);
                if (emitted_reg != '0)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_prev = 1'b1;
                end
                else
                begin
                    cmd.prev_clear = 1'b1;
                end
                state_next = ST_LAND;
            end
            ST_LAND:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            radius_reg  <= RADIUS_RESET;
            wp_reg      <= '0;
            pending_reg <= '0;
            emitted_reg <= '0;
            rd_ptr_reg  <= '0;
            remain_reg  <= '0;
            count_reg   <= '0;
            final_reg   <= 1'b0;
            in_ready    <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            in_ready  <= (state_next == ST_IDLE);
            if (cfg_we)
                radius_reg <= cfg_data;
            if (accept)
            begin
                wp_reg      <= wp_reg + ADDR_W'(1);
                pending_reg <= pending_reg + CNT_W'(1);
                final_reg   <= in_final;
            end
            if (state_reg == ST_CHECK)
            begin
                if (due)
                begin
                    rd_ptr_reg <= base - ADDR_W'(back);
                    remain_reg <= back + ahead + CNT_W'(1);
                    count_reg  <= back + ahead + CNT_W'(1);
                end
                else if (final_reg)
                begin
                    wp_reg      <= '0;
                    pending_reg <= '0;
                    emitted_reg <= '0;
                    final_reg   <= 1'b0;
                end
            end
            if (state_reg == ST_SUM)
            begin
                rd_ptr_reg <= rd_ptr_reg + ADDR_W'(1);
                remain_reg <= remain_reg - CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                pending_reg <= pending_reg - CNT_W'(1);
                if (emitted_reg != {CNT_W{1'b1}})
                    emitted_reg <= emitted_reg + CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/trajectory_smoothing_corrector.sv
// trajectory_smoothing_corrector: top level tying controller and datapath
// depends on tsc_pkg, tsc_controller, tsc_datapath, tsc_ram
//
// usage
//   s_axis carries one motion step item per frame; tlast marks the final
//   frame of a sequence. m_axis returns corrected steps; tlast marks the
//   last corrected step of a flushed sequence.
//   cfg_we/cfg_data write window_radius (0..63) while the block is idle.
// sequencing
//   one item at a time: s_axis_tready drops after an accept and returns once
//   every result it made due has been computed. each result reads its window
//   points from history ram, one read a cycle, then the previous point, then
//   runs the bit-serial divider (three lanes in parallel) and is handed off.
//   an item that makes no result returns to idle straight after the due check.
// reset
//   asynchronous, clears trajectory, counters and pointers; radius goes to 15.
//   history ram holds no reset value; only points of the running sequence
//   are ever read.
// stall
//   results wait in an output register; the block keeps accepting items
//   while one waits, and holds the next result until the register frees.
module trajectory_smoothing_corrector
    import tsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,       // window_radius
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // step_x[18:0], step_y[37:19], step_angle[56:38]
    input  logic        s_axis_tlast,   // final_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // fixed_x[23:0], fixed_y[47:24], fixed_angle[71:48]
    output logic        m_axis_tlast    // end_of_run
);

    tsc_cmd_t    cmd;
    tsc_status_t status;

    // sequencer and pointers
    tsc_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_final (s_axis_tlast),
        .cmd      (cmd),
        .status   (status)
    );

    // arithmetic, history and result register
    tsc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .steps     (s_axis_tdata[LANES*STEP_W-1:0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

>>> hw/rtl/tsc_checker.sv
// tsc_checker: port-level assertions for trajectory_smoothing_corrector
// bound to the top level; no package dependency
module tsc_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // an accepted item always closes the input side in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");

    // a fresh result is only produced while the input side is closed
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !s_axis_tready)
        else $error("result appeared while idle");

endmodule

bind trajectory_smoothing_corrector tsc_checker u_tsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
